[sv/cfq_pkg.sv]
package cfq_pkg;

   localparam int DEPTH  = 8;
   localparam int WORD_W = 32;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_DELETE  = 2'd1;
   localparam logic [1:0] OP_DISPLAY = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [WORD_W-1:0] value_in;
   } req_item_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] value_out;
      logic                     last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_INSERT,
      CMD_DELETE,
      CMD_DISP_FIRST,
      CMD_DISP_NEXT
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic one_held;
      logic scan_last;
   } dp_status_type;

   typedef enum logic {
      S_IDLE,
      S_DISPLAY
   } ctrl_state_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + 1'b1;
      end
      return result;
   endfunction

endpackage

[sv/circular_fifo_queue_core.sv]
// A result appears on rsp_* in the cycle after its item is taken.
// Insert and delete: one item per cycle while no display is in progress; busy stays low.
// Display: one result per held word (else one STATUS_EMPTY), one per cycle;
// busy is high from the second read to the last. The RAM read port sets that rate.
// Reset (synchronous, active high) empties the queue; the store is not cleared.
// The receiver cannot stall: every result is shown for exactly one cycle.
module circular_fifo_queue_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  cfq_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   output cfq_pkg::rsp_item_type rsp_data
);

   cfq_pkg::dp_cmd_type    dp_cmd;
   cfq_pkg::dp_status_type dp_status;

   cfq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_data.req_type),
      .dp_status(dp_status),
      .dp_cmd   (dp_cmd),
      .busy     (busy)
   );

   cfq_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .dp_cmd   (dp_cmd),
      .value_in (req_data.value_in),
      .dp_status(dp_status),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

[sv/cfq_ram.sv]
module cfq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/cfq_ctrl.sv]
module cfq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_type,
   input  cfq_pkg::dp_status_type dp_status,
   output cfq_pkg::dp_cmd_type    dp_cmd,
   output logic                   busy
);

   cfq_pkg::ctrl_state_type state_ff;
   cfq_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dp_cmd   = cfq_pkg::CMD_NONE;
      busy     = 1'b0;
      unique case (state_ff)
         cfq_pkg::S_IDLE: begin
            if (start) begin
               unique case (req_type)
                  cfq_pkg::OP_INSERT: begin
                     dp_cmd = cfq_pkg::CMD_INSERT;
                  end
                  cfq_pkg::OP_DELETE: begin
                     dp_cmd = cfq_pkg::CMD_DELETE;
                  end
                  cfq_pkg::OP_DISPLAY: begin
                     dp_cmd = cfq_pkg::CMD_DISP_FIRST;
                     if (!dp_status.empty && !dp_status.one_held) begin
                        state_in = cfq_pkg::S_DISPLAY;
                     end
                  end
                  default: begin
                     dp_cmd = cfq_pkg::CMD_NONE;
                  end
               endcase
            end
         end
         cfq_pkg::S_DISPLAY: begin
            busy   = 1'b1;
            dp_cmd = cfq_pkg::CMD_DISP_NEXT;
            if (dp_status.scan_last) begin
               state_in = cfq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cfq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[sv/cfq_dp.sv]
module cfq_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  cfq_pkg::dp_cmd_type              dp_cmd,
   input  logic signed [cfq_pkg::WORD_W-1:0] value_in,
   output cfq_pkg::dp_status_type           dp_status,
   output logic                             rsp_valid,
   output cfq_pkg::rsp_item_type            rsp_data
);

   logic [cfq_pkg::PTR_W-1:0]  head_ff, head_in;
   logic [cfq_pkg::PTR_W-1:0]  tail_ff, tail_in;
   logic [cfq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [cfq_pkg::PTR_W-1:0]  scan_ptr_ff, scan_ptr_in;
   logic [cfq_pkg::CNT_W-1:0]  scan_left_ff, scan_left_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 status_ff, status_in;
   logic                       last_ff, last_in;
   logic                       use_ram_ff, use_ram_in;

   logic                       wr_en;
   logic                       rd_en;
   logic [cfq_pkg::PTR_W-1:0]  rd_addr;
   logic [cfq_pkg::WORD_W-1:0] rd_data;
   logic                       full;
   logic                       empty;

   cfq_ram #(
      .WIDTH(cfq_pkg::WORD_W),
      .DEPTH(cfq_pkg::DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(tail_ff),
      .wr_data(value_in),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign full  = (count_ff == cfq_pkg::CNT_W'(cfq_pkg::DEPTH));
   assign empty = (count_ff == '0);

   assign dp_status.empty     = empty;
   assign dp_status.one_held  = (count_ff == cfq_pkg::CNT_W'(1));
   assign dp_status.scan_last = (scan_left_ff == cfq_pkg::CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         scan_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         scan_left_ff <= scan_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
      use_ram_ff  <= use_ram_in;
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      rsp_valid_in = 1'b0;
      status_in    = cfq_pkg::STATUS_OK;
      last_in      = 1'b1;
      use_ram_in   = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      unique case (dp_cmd)
         cfq_pkg::CMD_INSERT: begin
            rsp_valid_in = 1'b1;
            if (full) begin
               status_in = cfq_pkg::STATUS_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               tail_in  = cfq_pkg::next_ptr(tail_ff);
               count_in = count_ff + 1'b1;
            end
         end
         cfq_pkg::CMD_DELETE: begin
            rsp_valid_in = 1'b1;
            if (empty) begin
               status_in = cfq_pkg::STATUS_UNDERFLOW;
            end else begin
               rd_en      = 1'b1;
               use_ram_in = 1'b1;
               head_in    = cfq_pkg::next_ptr(head_ff);
               count_in   = count_ff - 1'b1;
            end
         end
         cfq_pkg::CMD_DISP_FIRST: begin
            rsp_valid_in = 1'b1;
            if (empty) begin
               status_in = cfq_pkg::STATUS_EMPTY;
            end else begin
               rd_en        = 1'b1;
               use_ram_in   = 1'b1;
               last_in      = (count_ff == cfq_pkg::CNT_W'(1));
               scan_ptr_in  = cfq_pkg::next_ptr(head_ff);
               scan_left_in = count_ff - 1'b1;
            end
         end
         cfq_pkg::CMD_DISP_NEXT: begin
            rsp_valid_in = 1'b1;
            rd_en        = 1'b1;
            rd_addr      = scan_ptr_ff;
            use_ram_in   = 1'b1;
            last_in      = (scan_left_ff == cfq_pkg::CNT_W'(1));
            scan_ptr_in  = cfq_pkg::next_ptr(scan_ptr_ff);
            scan_left_in = scan_left_ff - 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data.status    = status_ff;
   assign rsp_data.value_out = use_ram_ff ? rd_data : '0;
   assign rsp_data.last      = last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cfq_pkg::CNT_W'(cfq_pkg::DEPTH))
      else $error("element count above depth");

   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (head_ff == tail_ff))
      else $error("pointers disagree with count");

   a_scan_left: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd == cfq_pkg::CMD_DISP_NEXT) |-> (scan_left_ff != '0))
      else $error("display step with nothing left");

   a_scan_hold: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd == cfq_pkg::CMD_DISP_NEXT) |=> $stable(count_ff) && $stable(head_ff))
      else $error("queue changed during display");
`endif

endmodule

[tb/sv/circular_fifo_queue_checker.sv]
`timescale 1ns / 100ps
module circular_fifo_queue_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  cfq_pkg::req_item_type req_data,
   input  logic                  rsp_valid,
   input  cfq_pkg::rsp_item_type rsp_data,
   output int                    fail_count,
   output int                    pending_results
);
   import cfq_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic signed [WORD_W-1:0] ring_copy [DEPTH];
   logic [PTR_W-1:0]         head_slot;
   logic [PTR_W-1:0]         tail_slot;
   logic [CNT_W-1:0]         held_words;
   rsp_item_type             queued_rsp [$];
   int                       failures;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] slot);
      return PTR_W'((int'(slot) + 1) % DEPTH);
   endfunction

   task automatic queue_rsp(input logic [1:0] status, input logic signed [WORD_W-1:0] word,
                            input logic last);
      rsp_item_type rsp;
      rsp.status    = status;
      rsp.value_out = word;
      rsp.last      = last;
      queued_rsp.push_back(rsp);
   endtask

   task automatic predict_queue_op(input req_item_type item);
      logic [PTR_W-1:0] slot;
      case (item.req_type)
         OP_INSERT: begin
            if (held_words == CNT_W'(DEPTH)) begin
               queue_rsp(STATUS_OVERFLOW, '0, 1'b1);
            end else begin
               ring_copy[tail_slot] = item.value_in;
               tail_slot  = ring_next(tail_slot);
               held_words = held_words + 1'b1;
               queue_rsp(STATUS_OK, '0, 1'b1);
            end
         end
         OP_DELETE: begin
            if (held_words == '0) begin
               queue_rsp(STATUS_UNDERFLOW, '0, 1'b1);
            end else begin
               queue_rsp(STATUS_OK, ring_copy[head_slot], 1'b1);
               head_slot  = ring_next(head_slot);
               held_words = held_words - 1'b1;
            end
         end
         OP_DISPLAY: begin
            if (held_words == '0) begin
               queue_rsp(STATUS_EMPTY, '0, 1'b1);
            end else begin
               slot = head_slot;
               for (int i = 0; i < int'(held_words); i++) begin
                  queue_rsp(STATUS_OK, ring_copy[slot], i == int'(held_words) - 1);
                  slot = ring_next(slot);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         head_slot  = '0;
         tail_slot  = '0;
         held_words = '0;
         queued_rsp.delete();
      end else begin
         if (start && !busy) begin
            predict_queue_op(req_data);
         end
         if (rsp_valid) begin
            if (queued_rsp.size() == 0) begin
               if (failures < REPORT_LIMIT) begin
                  $display("unexpected result: status %0d value %0d last %0b",
                           rsp_data.status, rsp_data.value_out, rsp_data.last);
               end
               failures++;
            end else begin
               want = queued_rsp.pop_front();
               if (rsp_data.status !== want.status || rsp_data.value_out !== want.value_out ||
                   rsp_data.last !== want.last) begin
                  if (failures < REPORT_LIMIT) begin
                     $display("mismatch: expected status %0d value %0d last %0b, got %0d %0d %0b",
                              want.status, want.value_out, want.last,
                              rsp_data.status, rsp_data.value_out, rsp_data.last);
                  end
                  failures++;
               end
            end
         end
      end
      fail_count      <= failures;
      pending_results <= queued_rsp.size();
   end

endmodule

[tb/sv/circular_fifo_queue_core_tb.sv]
`timescale 1ns / 100ps
module circular_fifo_queue_core_tb;
   import cfq_pkg::*;

   localparam int         ITEM_TOTAL   = 400;
   localparam int         DRAIN_CYCLES = 4;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_item_type req_data = '0;
   logic         busy;
   logic         rsp_valid;
   rsp_item_type rsp_data;
   int           fail_count;
   int           pending_results;
   int           cycle_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   circular_fifo_queue_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   circular_fifo_queue_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   function automatic logic signed [WORD_W-1:0] random_word();
      logic signed [WORD_W-1:0] word;
      case ($urandom_range(9))
         0:       word = 32'sh8000_0000;
         1:       word = 32'sh7FFF_FFFF;
         2:       word = '0;
         3:       word = '1;
         default: word = $urandom();
      endcase
      return word;
   endfunction

   task automatic send_item(input logic [1:0] op, input logic signed [WORD_W-1:0] word,
                            input int idle_pct);
      req_item_type item;
      int           gap;
      item.req_type = op;
      item.value_in = word;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int count, input int idle_pct);
      int         sent;
      int         run_left;
      int         pick;
      bit         filling;
      logic [1:0] op;
      sent     = 0;
      run_left = 0;
      filling  = 1'b0;
      while (sent < count) begin
         if (run_left == 0) begin
            filling  = !filling;
            run_left = $urandom_range(4, 20);
         end
         run_left--;
         pick = $urandom_range(99);
         if (pick < 4) begin
            op = OP_UNUSED;
         end else if (pick < (filling ? 64 : 26)) begin
            op = OP_INSERT;
         end else if (pick < 86) begin
            op = OP_DELETE;
         end else begin
            op = OP_DISPLAY;
         end
         send_item(op, random_word(), idle_pct);
         if (op != OP_UNUSED) sent++;
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_DISPLAY, 32'sh1234_5678, 0);
      send_item(OP_DELETE, '0, 0);
      send_item(OP_UNUSED, '1, 0);
      send_item(OP_INSERT, 32'sh7FFF_FFFF, 0);
      send_item(OP_INSERT, 32'sh8000_0000, 0);
      send_item(OP_INSERT, '0, 0);
      send_item(OP_INSERT, '1, 0);
      send_item(OP_INSERT, 32'sh5555_5555, 0);
      send_item(OP_INSERT, 32'shAAAA_AAAA, 0);
      send_item(OP_INSERT, 32'sh0000_0001, 0);
      send_item(OP_INSERT, 32'sh1234_5678, 0);
      send_item(OP_INSERT, 32'sh0BAD_F00D, 0);
      send_item(OP_DISPLAY, '0, 0);
      send_item(OP_UNUSED, 32'sh7FFF_FFFF, 0);
      send_item(OP_DELETE, 32'sh8000_0000, 0);
      send_item(OP_DELETE, '0, 0);
      send_item(OP_DELETE, '1, 0);
      send_item(OP_INSERT, 32'sh0F0F_0F0F, 0);
      send_item(OP_INSERT, 32'shF0F0_F0F0, 0);
      send_item(OP_INSERT, 32'sh8000_0001, 0);
      send_item(OP_DISPLAY, '0, 0);
      send_item(OP_DELETE, '0, 0);
      send_item(OP_DISPLAY, '0, 0);

      wait_drained();
      random_phase(ITEM_TOTAL / 3, 33);
      wait_drained();
      random_phase(ITEM_TOTAL / 3, 68);
      random_phase(ITEM_TOTAL - 2 * (ITEM_TOTAL / 3), 0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
